// ----- rtl/ccs_pkg.sv -----
// Shared widths, constants, register indexes, state and handshake types of the column sum unit.
package ccs_pkg;

  // Field widths
  localparam int unsigned COL_W     = 7;
  localparam int unsigned ROW_W     = 9;
  localparam int unsigned COND_W    = 24;
  localparam int unsigned CUR_W     = 40;
  localparam int unsigned IN_DATA_W = 40;
  localparam int unsigned OUT_DATA_W = 48;

  // Configuration register widths
  localparam int unsigned VOLT_W   = 20;
  localparam int unsigned STEP_W   = 16;
  localparam int unsigned ACCESS_W = 30;
  localparam int unsigned SPAN_W   = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 30;

  // Datapath widths
  localparam int unsigned PROD_A_W   = 24;
  localparam int unsigned PROD_B_W   = 26;
  localparam int unsigned WIRE_W     = 31;
  localparam int unsigned DIVIDEND_W = 50;
  localparam int unsigned DIVISOR_W  = 51;

  // Scale constants
  localparam logic [DIVIDEND_W-1:0] INV_SCALE  = 50'd1000000000000000;
  localparam logic [DIVIDEND_W-1:0] VOLT_SCALE = 50'd1000000000;
  localparam logic [CUR_W-1:0]      ACC_MAX    = {CUR_W{1'b1}};

  // Register reset values
  localparam logic [VOLT_W-1:0]   VOLT_RST   = 20'd500000;
  localparam logic [STEP_W-1:0]   ROW_STEP_RST = 16'd152;
  localparam logic [STEP_W-1:0]   COL_STEP_RST = 16'd152;
  localparam logic [ACCESS_W-1:0] ACCESS_RST = 30'd15000000;
  localparam logic [SPAN_W-1:0]   SPAN_RST   = 10'd400;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_READ_VOLTAGE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_STEP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COL_STEP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACCESS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_SPAN     = 3'd4;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WIRE,
    ST_DIV_INV,
    ST_DIV_CUR,
    ST_ACC
  } ccs_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_cell;
    logic calc_wire;
    logic start_inv;
    logic start_cur;
    logic accumulate;
    logic emit;
  } ccs_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic skip;
    logic last;
    logic out_free;
  } ccs_status_t;

endpackage

// ----- rtl/ccs_divider.sv -----
// Restoring radix-2 divider, one quotient bit per cycle.
module ccs_divider (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [ccs_pkg::DIVIDEND_W-1:0]    dividend,
  input  logic [ccs_pkg::DIVISOR_W-1:0]     divisor,
  output logic                              busy,
  output logic                              done,
  output logic [ccs_pkg::DIVIDEND_W-1:0]    quotient
);
  import ccs_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W);

  logic [DIVISOR_W-1:0]  rem_r,  rem_nxt;
  logic [DIVIDEND_W-1:0] quo_r,  quo_nxt;
  logic [DIVISOR_W-1:0]  div_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r, done_r;
  logic [DIVISOR_W:0]    trial;
  logic                  ge;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    trial   = {rem_r, quo_r[DIVIDEND_W-1]};
    ge      = (trial >= {1'b0, div_r});
    rem_nxt = ge ? DIVISOR_W'(trial - {1'b0, div_r}) : trial[DIVISOR_W-1:0];
    quo_nxt = {quo_r[DIVIDEND_W-2:0], ge};
  end

  // Control: busy flag, bit counter, done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIVIDEND_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        done_r <= 1'b0;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // Operand and partial result registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- rtl/ccs_datapath.sv -----
// Datapath: configuration registers, wire resistance, divider operands, accumulator, output register.
module ccs_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ccs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ccs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic [ccs_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                              in_tuser,
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ccs_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  ccs_pkg::ccs_cmd_t                 cmd,
  output ccs_pkg::ccs_status_t              st
);
  import ccs_pkg::*;

  // Configuration registers
  logic [VOLT_W-1:0]   volt_r;
  logic [STEP_W-1:0]   row_step_r;
  logic [STEP_W-1:0]   col_step_r;
  logic [ACCESS_W-1:0] access_r;
  logic [SPAN_W-1:0]   span_r;

  // Cell registers
  logic [COL_W-1:0]      col_r;
  logic [COND_W-1:0]     cond_r;
  logic                  active_r;
  logic                  last_r;
  logic [PROD_A_W-1:0]   prod_a_r, prod_a_nxt;
  logic [PROD_B_W-1:0]   prod_b_r, prod_b_nxt;
  logic [DIVIDEND_W-1:0] num_r,    num_nxt;
  logic [WIRE_W-1:0]     wire_r,   wire_nxt;

  // Accumulator and output
  logic [CUR_W-1:0]      acc_r;
  logic [CUR_W-1:0]      out_cur_r;
  logic [COL_W-1:0]      out_id_r;
  logic                  out_valid_r;

  // Divider hookup
  logic                  div_start;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic                  div_busy, div_done;
  logic [DIVIDEND_W-1:0] div_quotient;

  logic [COL_W-1:0]      in_col;
  logic [ROW_W-1:0]      in_row;
  logic [COND_W-1:0]     in_cond;
  logic [SPAN_W-1:0]     row_dist;
  logic                  skip;
  logic [DIVIDEND_W-1:0] cur;
  logic [DIVIDEND_W:0]   sum;
  logic [CUR_W-1:0]      sat;

  assign in_col  = in_tdata[COL_W-1:0];
  assign in_row  = in_tdata[COL_W+ROW_W-1:COL_W];
  assign in_cond = in_tdata[COL_W+ROW_W+COND_W-1:COL_W+ROW_W];

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volt_r     <= VOLT_RST;
      row_step_r <= ROW_STEP_RST;
      col_step_r <= COL_STEP_RST;
      access_r   <= ACCESS_RST;
      span_r     <= SPAN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_READ_VOLTAGE: volt_r     <= cfg_wdata[VOLT_W-1:0];
        REG_ROW_STEP:     row_step_r <= cfg_wdata[STEP_W-1:0];
        REG_COL_STEP:     col_step_r <= cfg_wdata[STEP_W-1:0];
        REG_ACCESS:       access_r   <= cfg_wdata[ACCESS_W-1:0];
        REG_ROW_SPAN:     span_r     <= cfg_wdata[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  // Wire resistance terms and numerator of the cell current
  always_comb begin
    row_dist   = (span_r > SPAN_W'(in_row)) ? SPAN_W'(span_r - SPAN_W'(in_row)) : '0;
    prod_a_nxt = PROD_A_W'((PROD_A_W'(in_col) + PROD_A_W'(1)) * PROD_A_W'(row_step_r));
    prod_b_nxt = PROD_B_W'(PROD_B_W'(row_dist) * PROD_B_W'(col_step_r));
    num_nxt    = DIVIDEND_W'(DIVIDEND_W'(volt_r) * VOLT_SCALE);
    wire_nxt   = WIRE_W'(prod_a_r) + WIRE_W'(prod_b_r) + WIRE_W'(access_r);
  end

  // Capture the cell on transfer, sum the wire terms in the next cycle
  always_ff @(posedge clk) begin
    if (cmd.load_cell) begin
      col_r    <= in_col;
      cond_r   <= in_cond;
      active_r <= in_tuser;
      last_r   <= in_tlast;
      prod_a_r <= prod_a_nxt;
      prod_b_r <= prod_b_nxt;
      num_r    <= num_nxt;
    end
    if (cmd.calc_wire) begin
      wire_r <= wire_nxt;
    end
  end

  // Divider operands: first the inverse conductance, then the current
  always_comb begin
    div_start    = cmd.start_inv | cmd.start_cur;
    div_dividend = cmd.start_cur ? num_r : INV_SCALE;
    div_divisor  = cmd.start_cur ? (DIVISOR_W'(div_quotient) + DIVISOR_W'(wire_r))
                                 : DIVISOR_W'(cond_r);
  end

  ccs_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Saturating add of the cell current
  always_comb begin
    skip = !active_r || (cond_r == '0);
    cur  = skip ? '0 : div_quotient;
    sum  = (DIVIDEND_W+1)'(acc_r) + (DIVIDEND_W+1)'(cur);
    sat  = (sum > (DIVIDEND_W+1)'(ACC_MAX)) ? ACC_MAX : sum[CUR_W-1:0];
  end

  // Accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (cmd.emit) begin
      acc_r <= '0;
    end else if (cmd.accumulate) begin
      acc_r <= sat;
    end
  end

  // Output register: load on emit, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_cur_r <= sat;
      out_id_r  <= col_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_id_r, out_cur_r};

  assign st.div_busy = div_busy;
  assign st.div_done = div_done;
  assign st.skip     = skip;
  assign st.last     = last_r;
  assign st.out_free = !out_valid_r || out_tready;

endmodule

// ----- rtl/ccs_ctrl.sv -----
// Controller: per cell, wire sum, two divisions unless skipped, then accumulation.
module ccs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  ccs_pkg::ccs_status_t st,
  output ccs_pkg::ccs_cmd_t    cmd
);
  import ccs_pkg::*;

  ccs_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_cell = 1'b1;
          state_nxt     = ST_WIRE;
        end
      end
      ST_WIRE: begin
        cmd.calc_wire = 1'b1;
        if (st.skip) begin
          state_nxt = ST_ACC;
        end else begin
          cmd.start_inv = 1'b1;
          state_nxt     = ST_DIV_INV;
        end
      end
      ST_DIV_INV: begin
        if (st.div_done) begin
          cmd.start_cur = 1'b1;
          state_nxt     = ST_DIV_CUR;
        end
      end
      ST_DIV_CUR: begin
        if (st.div_done) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        if (!st.last) begin
          cmd.accumulate = 1'b1;
          state_nxt      = ST_IDLE;
        end else if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_to_wire: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_WIRE))
    else $error("cell transfer not followed by wire sum");

  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.start_inv || cmd.start_cur) |-> !st.div_busy)
    else $error("divider started while busy");

  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> st.out_free)
    else $error("column sum emitted over a pending result");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    st.div_done |-> (state_r == ST_DIV_INV || state_r == ST_DIV_CUR))
    else $error("divider done outside a division state");
`endif

endmodule

// ----- rtl/crossbar_column_current_sum_unit.sv -----
// Top level of the crossbar column read-current sum unit.
//
//  channel  dir  handshake              payload
//  in_      in   in_tvalid/in_tready    tdata: col, row, conductance; tuser: row active; tlast
//  out_     out  out_tvalid/out_tready  tdata: column current, column id
//  cfg_     in   cfg_we                 cfg_index, cfg_wdata
//
// An inactive cell or one of zero conductance skips the divider. Any other cell makes two
// passes through the shared one-bit-per-cycle divider.
// Reset is synchronous, active low; it restores register defaults and clears the sum.
// A finished column sum waits in the output register; the next cell is taken meanwhile,
// and only a further column end stalls until that sum is transferred.
module crossbar_column_current_sum_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ccs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ccs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // in_tdata: col_index[6:0], row_index[15:7], conductance_ps[39:16]
  input  logic [ccs_pkg::IN_DATA_W-1:0]     in_tdata,
  // in_tuser: row_active[0]
  input  logic                              in_tuser,
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_tdata: column_current_pa[39:0], column_id[46:40], zero[47]
  output logic [ccs_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import ccs_pkg::*;

  ccs_cmd_t    cmd;
  ccs_status_t st;

  ccs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  ccs_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .st         (st)
  );

endmodule
